### rtl/core/fat12_pkg.sv
// Shared types and constants for the FAT12 allocation-table engine.
package fat12_pkg;

    localparam int unsigned ADDR_W  = 13;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned ENTRY_W = 12;
    localparam int unsigned FUNC_W  = 3;

    // Operation codes carried on the input channel.
    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_BEGIN = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_STEP  = 3'd4;

    // The chain end marker lives in entry 1.
    localparam logic [ENTRY_W-1:0] MARKER_INDEX = 12'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH_A,
        ST_FETCH_B,
        ST_FETCH_C,
        ST_WRITE_A,
        ST_WRITE_B,
        ST_RESULT
    } seq_state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] wdata;
    } mem_req_t;

    typedef struct packed {
        logic               valid;
        logic [ENTRY_W-1:0] entry;
        logic               done;
    } result_t;

endpackage

### rtl/core/fat12_mem.sv
// Single-port table byte store with a registered read.
module fat12_mem
    import fat12_pkg::*;
#(
    parameter int unsigned DEPTH = 6144
) (
    input  logic              aclk,
    input  mem_req_t          req,
    output logic [BYTE_W-1:0] rdata
);

    localparam int unsigned AW = $clog2(DEPTH);

    logic [BYTE_W-1:0] mem_q [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem_q[req.addr[AW-1:0]] <= req.wdata;
        end
        rdata_reg <= mem_q[req.addr[AW-1:0]];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/fat12_seq.sv
// Operation sequencer: byte fetches, entry assembly, write-back and chain state.
module fat12_seq
    import fat12_pkg::*;
#(
    parameter int unsigned ENTRY_COUNT = 4096
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [FUNC_W-1:0]  s_func,
    input  logic [ADDR_W-1:0]  s_byte_addr,
    input  logic [BYTE_W-1:0]  s_byte_data,
    input  logic [ENTRY_W-1:0] s_cluster,
    input  logic [ENTRY_W-1:0] s_entry_in,
    output mem_req_t           mem_req,
    input  logic [BYTE_W-1:0]  mem_rdata,
    output result_t            res,
    input  logic               res_ready
);

    localparam int unsigned TABLE_BYTES = (3 * ENTRY_COUNT + 1) / 2;
    localparam logic [ADDR_W:0]  EC_LIMIT    = (ADDR_W + 1)'(ENTRY_COUNT);
    localparam logic [ADDR_W:0]  BYTE_LIMIT  = (ADDR_W + 1)'(TABLE_BYTES);

    seq_state_t         state_reg, state_next;
    logic [FUNC_W-1:0]  op_reg, op_next;
    logic [ENTRY_W-1:0] clus_reg, clus_next;
    logic [ENTRY_W-1:0] val_reg, val_next;
    logic [ENTRY_W-1:0] idx_reg, idx_next;
    logic               phase_reg, phase_next;
    logic [BYTE_W-1:0]  b0_reg, b0_next;
    logic [BYTE_W-1:0]  b1_reg, b1_next;
    logic [ENTRY_W-1:0] marker_reg, marker_next;
    logic [ENTRY_W-1:0] pos_reg, pos_next;
    logic               live_reg, live_next;
    logic [ENTRY_W-1:0] res_entry_reg, res_entry_next;
    logic               res_done_reg, res_done_next;

    logic [ADDR_W-1:0]  addr0;
    logic [ADDR_W-1:0]  addr1;
    logic [ENTRY_W-1:0] ent;
    logic [BYTE_W-1:0]  wdata0;
    logic [BYTE_W-1:0]  wdata1;
    logic               clus_in_range;
    logic               pos_in_range;
    logic               load_in_range;

    // Entry 2k starts at byte 3k, entry 2k+1 at byte 3k+1.
    assign addr0 = {1'b0, idx_reg[ENTRY_W-1:1], 1'b0}
                 + {2'b00, idx_reg[ENTRY_W-1:1]}
                 + {{(ADDR_W-1){1'b0}}, idx_reg[0]};
    assign addr1 = addr0 + {{(ADDR_W-1){1'b0}}, 1'b1};

    // The second byte arrives straight from the store in the last fetch cycle.
    assign ent = idx_reg[0] ? {mem_rdata, b0_reg[7:4]}
                            : {mem_rdata[3:0], b0_reg};

    // Only the nibble shared with the neighbouring entry is kept.
    assign wdata0 = idx_reg[0] ? {val_reg[3:0], b0_reg[3:0]} : val_reg[7:0];
    assign wdata1 = idx_reg[0] ? val_reg[11:4] : {b1_reg[7:4], val_reg[11:8]};

    assign clus_in_range = {2'b00, s_cluster} < EC_LIMIT;
    assign pos_in_range  = {2'b00, pos_reg} < EC_LIMIT;
    assign load_in_range = {1'b0, s_byte_addr} < BYTE_LIMIT;

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= 1'b0;
            pos_reg   <= '0;
            live_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            live_reg  <= live_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        clus_reg      <= clus_next;
        val_reg       <= val_next;
        idx_reg       <= idx_next;
        b0_reg        <= b0_next;
        b1_reg        <= b1_next;
        marker_reg    <= marker_next;
        res_entry_reg <= res_entry_next;
        res_done_reg  <= res_done_next;
    end

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        clus_next      = clus_reg;
        val_next       = val_reg;
        idx_next       = idx_reg;
        phase_next     = phase_reg;
        b0_next        = b0_reg;
        b1_next        = b1_reg;
        marker_next    = marker_reg;
        pos_next       = pos_reg;
        live_next      = live_reg;
        res_entry_next = res_entry_reg;
        res_done_next  = res_done_reg;
        mem_req        = '0;
        res            = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next        = s_func;
                    clus_next      = s_cluster;
                    val_next       = s_entry_in;
                    phase_next     = 1'b0;
                    res_entry_next = '0;
                    res_done_next  = 1'b0;
                    state_next     = ST_RESULT;
                    unique case (s_func)
                        FUNC_LOAD: begin
                            mem_req.we    = load_in_range;
                            mem_req.addr  = s_byte_addr;
                            mem_req.wdata = s_byte_data;
                        end
                        FUNC_READ: begin
                            if (clus_in_range) begin
                                idx_next   = s_cluster;
                                state_next = ST_FETCH_A;
                            end
                        end
                        FUNC_WRITE: begin
                            res_entry_next = s_entry_in;
                            if (clus_in_range) begin
                                idx_next   = s_cluster;
                                state_next = ST_FETCH_A;
                            end
                        end
                        FUNC_BEGIN: begin
                            idx_next   = MARKER_INDEX;
                            state_next = ST_FETCH_A;
                        end
                        FUNC_STEP: begin
                            if (live_reg) begin
                                idx_next   = MARKER_INDEX;
                                state_next = ST_FETCH_A;
                            end else begin
                                res_done_next = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FETCH_A: begin
                mem_req.addr = addr0;
                state_next   = ST_FETCH_B;
            end
            ST_FETCH_B: begin
                mem_req.addr = addr1;
                b0_next      = mem_rdata;
                state_next   = ST_FETCH_C;
            end
            ST_FETCH_C: begin
                b1_next    = mem_rdata;
                state_next = ST_RESULT;
                case (op_reg)
                    FUNC_READ: begin
                        res_entry_next = ent;
                    end
                    FUNC_WRITE: begin
                        state_next = ST_WRITE_A;
                    end
                    FUNC_BEGIN: begin
                        pos_next = clus_reg;
                        if (clus_reg == '0 || clus_reg == ent) begin
                            live_next     = 1'b0;
                            res_done_next = 1'b1;
                        end else begin
                            live_next      = 1'b1;
                            res_entry_next = clus_reg;
                        end
                    end
                    FUNC_STEP: begin
                        if (!phase_reg) begin
                            marker_next = ent;
                            if (pos_in_range) begin
                                phase_next = 1'b1;
                                idx_next   = pos_reg;
                                state_next = ST_FETCH_A;
                            end else begin
                                live_next     = 1'b0;
                                res_done_next = 1'b1;
                            end
                        end else if (ent == '0 || ent == marker_reg) begin
                            live_next     = 1'b0;
                            res_done_next = 1'b1;
                        end else begin
                            pos_next       = ent;
                            res_entry_next = ent;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_WRITE_A: begin
                mem_req.we    = 1'b1;
                mem_req.addr  = addr0;
                mem_req.wdata = wdata0;
                state_next    = ST_WRITE_B;
            end
            ST_WRITE_B: begin
                mem_req.we    = 1'b1;
                mem_req.addr  = addr1;
                mem_req.wdata = wdata1;
                state_next    = ST_RESULT;
            end
            ST_RESULT: begin
                res.valid = 1'b1;
                res.entry = res_entry_reg;
                res.done  = res_done_reg;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/fat12_table_chain_engine.sv
// Top level of the FAT12 allocation-table engine: sequencer, byte store, result register.
// One item is worked at a time; the single-port byte store sets the pace.
// After accept, load byte, unknown codes, a step with no chain and an out-of-range cluster go
// straight to ST_RESULT; read and begin pass FETCH_A/B/C; write adds WRITE_A/B; a step reads
// the marker, then its in-range position; the next item waits for the result to be registered.
// Synchronous active-low reset clears the sequencer, the chain state and the result valid flag;
// the table bytes are not cleared and read as unknown until loaded.
module fat12_table_chain_engine
    import fat12_pkg::*;
#(
    parameter int unsigned ENTRY_COUNT = 4096
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [FUNC_W-1:0]  s_func,
    input  logic [ADDR_W-1:0]  s_byte_addr,
    input  logic [BYTE_W-1:0]  s_byte_data,
    input  logic [ENTRY_W-1:0] s_cluster,
    input  logic [ENTRY_W-1:0] s_entry_in,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [ENTRY_W-1:0] m_entry_out,
    output logic               m_chain_done
);

    // Two 12-bit entries share every three bytes; an odd count needs half a group more.
    localparam int unsigned TABLE_BYTES = (3 * ENTRY_COUNT + 1) / 2;

    mem_req_t          mem_req;
    logic [BYTE_W-1:0] mem_rdata;
    result_t           res;
    logic              res_ready;

    logic               m_valid_reg, m_valid_next;
    logic [ENTRY_W-1:0] m_entry_reg, m_entry_next;
    logic               m_done_reg, m_done_next;

    fat12_seq #(
        .ENTRY_COUNT (ENTRY_COUNT)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_byte_addr (s_byte_addr),
        .s_byte_data (s_byte_data),
        .s_cluster   (s_cluster),
        .s_entry_in  (s_entry_in),
        .mem_req     (mem_req),
        .mem_rdata   (mem_rdata),
        .res         (res),
        .res_ready   (res_ready)
    );

    fat12_mem #(
        .DEPTH (TABLE_BYTES)
    ) u_mem (
        .aclk  (aclk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    // The output register takes a new beat whenever it is empty or being drained,
    // so the sequencer never waits on a consumer that keeps up.
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_entry_next = m_entry_reg;
        m_done_next  = m_done_reg;
        if (res_ready) begin
            m_valid_next = res.valid;
            m_entry_next = res.entry;
            m_done_next  = res.done;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_entry_reg <= m_entry_next;
        m_done_reg  <= m_done_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_entry_out  = m_entry_reg;
    assign m_chain_done = m_done_reg;

endmodule

### rtl/core/fat12_chk.sv
// Port-level checker for the FAT12 allocation-table engine, with its bind.
module fat12_chk
    import fat12_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [ENTRY_W-1:0] m_entry_out,
    input logic               m_chain_done
);

    // A result beat that is not taken holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_entry_out) && $stable(m_chain_done))
        else $error("result beat changed while stalled");

    // An ended chain carries no cluster.
    a_done_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_chain_done |-> m_entry_out == '0)
        else $error("chain_done beat with non-zero entry");

    // Only one item is worked at a time.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second beat accepted while busy");

    // Reset leaves the block empty and ready.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not idle after reset");

endmodule

bind fat12_table_chain_engine fat12_chk u_fat12_chk (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_entry_out  (m_entry_out),
    .m_chain_done (m_chain_done)
);
